@@ rtl/ptl_pkg.sv @@
// Types and constants shared by the perspective texel lookup unit.
`default_nettype none
package ptl_pkg;

  // request kinds
  localparam logic [1:0] REQ_VERTEX = 2'd0;
  localparam logic [1:0] REQ_TEXEL  = 2'd1;
  localparam logic [1:0] REQ_PIXEL  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] VIDX_NONE  = 2'd3;

  localparam int COORD_W   = 12;
  localparam int STORE_AW  = 12;
  localparam int TEX_DEPTH = 2 ** STORE_AW;
  localparam int COLOR_W   = 32;
  localparam int UV_W      = 17;
  localparam int W_W       = 32;

  localparam int DIFF_W  = 13;              // difference of two screen coords
  localparam int PROD_W  = 2 * DIFF_W;      // edge product
  localparam int AREA_W  = PROD_W + 1;      // edge function
  localparam int DIV1_NW = 56;              // |edge| * 2^30, or u * 2^32
  localparam int DIV1_DW = 32;              // |area| or w
  localparam int TERM_W  = 49;              // per-vertex u/w, v/w, 1/w (unsigned Q17.32)
  localparam int LO_W    = 25;
  localparam int HI_W    = TERM_W - LO_W;
  localparam int WT_W    = 32;              // Q2.30 weight
  localparam int FULL_W  = 84;              // weight * term before the shift
  localparam int M_W     = 51;              // weight * term / 2^30
  localparam int SUM_W   = 53;
  localparam int SCALE_W = 11;              // texture size up to 1024
  localparam int SPROD_W = SUM_W + SCALE_W + 1;
  localparam int DIV2_NW = 64;
  localparam int DIV2_DW = SUM_W;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic [1:0]                 vertex_index;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic [W_W-1:0]             vert_w;
    logic [UV_W-1:0]            tex_u;
    logic [UV_W-1:0]            tex_v;
    logic [STORE_AW-1:0]        texel_addr;
    logic [COLOR_W-1:0]         texel_color;
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  pix_x;
    logic signed [COORD_W-1:0]  pix_y;
    logic [COLOR_W-1:0]         color;
    logic                       degenerate;
  } res_t;

  // per-item data that rides along the pipeline
  typedef struct packed {
    logic [1:0]                 kind;
    logic [1:0]                 vidx;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic [STORE_AW-1:0]        taddr;
    logic [COLOR_W-1:0]         tcolor;
    logic                       deg;
    logic                       neg_a;
    logic                       neg_b;
    logic                       rz;
  } side_t;

endpackage
`default_nettype wire

@@ rtl/perspective_texel_lookup_unit.sv @@
// Top level: perspective-correct texel lookup pipeline for one stored triangle.
//
//  channel | signals                      | payload
//  --------+------------------------------+----------------------------------------
//  cmd     | cmd_valid, cmd_stall, cmd    | vertex load, texel write or pixel shade
//  res     | res_valid, res_stall, res    | one result per shaded pixel
//
// One item enters per cycle while no stalled result holds the pipeline.
// Latency is set by two bit-per-stage divider pipelines (56 stages for the
// barycentric weights and per-vertex u/w, v/w and 1/w terms, 64 for the texel coordinates).
// Synchronous reset clears only the valid bits; vertex and texture stores start undefined.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module perspective_texel_lookup_unit
  import ptl_pkg::*;
#(
  parameter int TEX_WIDTH  = 64,
  parameter int TEX_HEIGHT = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  req_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int TXW = (TEX_WIDTH > 1) ? $clog2(TEX_WIDTH) : 1;
  localparam int TYW = (TEX_HEIGHT > 1) ? $clog2(TEX_HEIGHT) : 1;
  localparam int ROW_W = SCALE_W + TYW;
  localparam logic [SCALE_W-1:0] SCL_W = SCALE_W'(TEX_WIDTH);
  localparam logic [SCALE_W-1:0] SCL_H = SCALE_W'(TEX_HEIGHT);
  localparam logic [DIV1_NW-1:0] R_NUM = DIV1_NW'(1) << 48;
  localparam logic [DIV1_NW-1:0] MAG_MAX = DIV1_NW'(32'h7FFF_FFFF);
  localparam logic [DIV1_NW-1:0] MAG_MIN = DIV1_NW'(32'h8000_0000);
  localparam logic signed [WT_W-1:0] WT_MAX = {1'b0, {(WT_W-1){1'b1}}};
  localparam logic signed [WT_W-1:0] WT_MIN = {1'b1, {(WT_W-1){1'b0}}};
  localparam logic signed [WT_W+1:0] ONE_Q30 = (WT_W + 2)'(34'sh0_4000_0000);
  localparam logic [UV_W-1:0] UV_ONE = UV_W'(65536);

  function automatic logic signed [WT_W-1:0] sat_div(input logic [DIV1_NW-1:0] mag,
                                                      input logic neg);
    logic signed [WT_W-1:0] r;
    if (neg) begin
      r = (mag >= MAG_MIN) ? WT_MIN : -$signed(WT_W'(mag));
    end else begin
      r = (mag > MAG_MAX) ? WT_MAX : $signed(WT_W'(mag));
    end
    return r;
  endfunction

  logic adv;
  assign adv       = !(res_valid && res_stall);
  assign cmd_stall = !adv;

  // ---------------- stage 1: accepted item, vertex position store
  logic v1;
  req_t c1;
  logic signed [COORD_W-1:0] vpx [3];
  logic signed [COORD_W-1:0] vpy [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1 <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1 && c1.req_type == REQ_VERTEX && c1.vertex_index != VIDX_NONE) begin
      vpx[c1.vertex_index] <= c1.pos_x;
      vpy[c1.vertex_index] <= c1.pos_y;
    end
  end

  logic signed [DIFF_W-1:0] dif1 [10];
  logic [W_W-1:0]  wfix1;
  logic [UV_W-1:0] vf1;
  side_t           side1;

  always_comb begin
    dif1[0] = DIFF_W'(vpx[1]) - DIFF_W'(vpx[0]);
    dif1[1] = DIFF_W'(vpy[2]) - DIFF_W'(vpy[0]);
    dif1[2] = DIFF_W'(vpy[1]) - DIFF_W'(vpy[0]);
    dif1[3] = DIFF_W'(vpx[2]) - DIFF_W'(vpx[0]);
    dif1[4] = DIFF_W'(vpx[2]) - DIFF_W'(vpx[1]);
    dif1[5] = DIFF_W'(c1.pos_y) - DIFF_W'(vpy[1]);
    dif1[6] = DIFF_W'(c1.pos_x) - DIFF_W'(vpx[1]);
    dif1[7] = DIFF_W'(vpy[2]) - DIFF_W'(vpy[1]);
    dif1[8] = DIFF_W'(c1.pos_x) - DIFF_W'(vpx[0]);
    dif1[9] = DIFF_W'(c1.pos_y) - DIFF_W'(vpy[0]);
    // a zero w behaves as the smallest positive w
    wfix1 = (c1.vert_w == '0) ? W_W'(1) : c1.vert_w;
    vf1   = (c1.tex_v > UV_ONE) ? '0 : UV_W'(UV_ONE - c1.tex_v);
    side1        = '0;
    side1.kind   = c1.req_type;
    side1.vidx   = c1.vertex_index;
    side1.x      = c1.pos_x;
    side1.y      = c1.pos_y;
    side1.taddr  = c1.texel_addr;
    side1.tcolor = c1.texel_color;
  end

  // ---------------- stage 2: differences
  logic v2;
  side_t s2;
  logic signed [DIFF_W-1:0] dif2 [10];
  logic [W_W-1:0]  w2;
  logic [UV_W-1:0] u2, vf2;

  // ---------------- stage 3: edge products
  logic v3;
  side_t s3;
  logic signed [PROD_W-1:0] pr3 [6];
  logic [W_W-1:0]  w3;
  logic [UV_W-1:0] u3, vf3;

  // ---------------- stage 4: area and edge functions
  logic v4;
  side_t s4;
  logic signed [AREA_W-1:0] area4, na4, nb4;
  logic [W_W-1:0]  w4;
  logic [UV_W-1:0] u4, vf4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2   <= side1;
      dif2 <= dif1;
      w2   <= wfix1;
      u2   <= c1.tex_u;
      vf2  <= vf1;

      s3     <= s2;
      pr3[0] <= dif2[0] * dif2[1];
      pr3[1] <= dif2[2] * dif2[3];
      pr3[2] <= dif2[4] * dif2[5];
      pr3[3] <= dif2[6] * dif2[7];
      pr3[4] <= dif2[8] * dif2[1];
      pr3[5] <= dif2[3] * dif2[9];
      w3     <= w2;
      u3     <= u2;
      vf3    <= vf2;

      s4    <= s3;
      area4 <= AREA_W'(pr3[0]) - AREA_W'(pr3[1]);
      na4   <= AREA_W'(pr3[2]) - AREA_W'(pr3[3]);
      nb4   <= AREA_W'(pr3[4]) - AREA_W'(pr3[5]);
      w4    <= w3;
      u4    <= u3;
      vf4   <= vf3;
    end
  end

  // divider operands: weights for a pixel or texel item, u/w, v/w and 1/w for a vertex
  logic [AREA_W-1:0]  abs_area, abs_na, abs_nb;
  logic [DIV1_NW-1:0] num_a, num_b, num_r;
  logic [DIV1_DW-1:0] den_ab, den_r;
  side_t              s4x;

  always_comb begin
    abs_area = area4[AREA_W-1] ? AREA_W'(-area4) : AREA_W'(area4);
    abs_na   = na4[AREA_W-1] ? AREA_W'(-na4) : AREA_W'(na4);
    abs_nb   = nb4[AREA_W-1] ? AREA_W'(-nb4) : AREA_W'(nb4);
    s4x       = s4;
    s4x.deg   = (area4 == '0);
    s4x.neg_a = na4[AREA_W-1] ^ area4[AREA_W-1];
    s4x.neg_b = nb4[AREA_W-1] ^ area4[AREA_W-1];
    if (s4.kind == REQ_VERTEX) begin
      num_a  = DIV1_NW'({u4, 32'd0});
      num_b  = DIV1_NW'({vf4, 32'd0});
      num_r  = R_NUM;
      den_ab = w4;
      den_r  = w4;
    end else begin
      num_a  = DIV1_NW'({abs_na, 30'd0});
      num_b  = DIV1_NW'({abs_nb, 30'd0});
      num_r  = '0;
      den_ab = DIV1_DW'(abs_area);
      den_r  = DIV1_DW'(1);
    end
  end

  logic [DIV1_NW-1:0] qa, qb, qr;
  logic               ve;
  side_t              se;

  ptl_div #(.NUM_W(DIV1_NW), .DEN_W(DIV1_DW), .MOD(2)) u_div_a (
    .clk(clk), .en(adv), .num(num_a), .den(den_ab), .quot(qa), .qmod()
  );
  ptl_div #(.NUM_W(DIV1_NW), .DEN_W(DIV1_DW), .MOD(2)) u_div_b (
    .clk(clk), .en(adv), .num(num_b), .den(den_ab), .quot(qb), .qmod()
  );
  ptl_div #(.NUM_W(DIV1_NW), .DEN_W(DIV1_DW), .MOD(2)) u_div_r (
    .clk(clk), .en(adv), .num(num_r), .den(den_r), .quot(qr), .qmod()
  );
  ptl_delay #(.W($bits(side_t)), .DEPTH(DIV1_NW)) u_dly_1 (
    .clk(clk), .rst(rst), .en(adv), .v_in(v4), .d_in(s4x), .v_out(ve), .d_out(se)
  );

  // ---------------- divider exit: per-vertex term store, weight saturation
  logic [TERM_W-1:0] tu [3];
  logic [TERM_W-1:0] tv [3];
  logic [TERM_W-1:0] tr [3];

  always_ff @(posedge clk) begin
    if (adv && ve && se.kind == REQ_VERTEX && se.vidx != VIDX_NONE) begin
      tu[se.vidx] <= TERM_W'(qa);
      tv[se.vidx] <= TERM_W'(qb);
      tr[se.vidx] <= TERM_W'(qr);
    end
  end

  logic v6, v7, v8, v9, v10, v11, v12;
  side_t s6, s7, s8, s9, s10, s11, s12;
  logic signed [WT_W-1:0]   alpha6, beta6;
  logic [TERM_W-1:0]        term6 [9];
  logic [TERM_W-1:0]        term7 [9];
  logic signed [WT_W-1:0]   wt7 [3];
  logic signed [WT_W+HI_W:0] p8 [9];
  logic signed [WT_W+LO_W:0] q8 [9];
  logic signed [M_W-1:0]    m9 [9];
  logic signed [SUM_W-1:0]  su10, sv10, sr10;
  logic signed [SPROD_W-1:0] pu11, pv11;
  logic signed [SUM_W-1:0]  sr11;
  logic [DIV2_NW-1:0]       nu12, nv12;
  logic [DIV2_DW-1:0]       dr12;

  logic signed [WT_W+1:0]   gsum;
  logic signed [WT_W-1:0]   gamma6;
  logic signed [FULL_W-1:0] full8 [9];
  side_t                    s11x;

  always_comb begin
    gsum = ONE_Q30 - (WT_W + 2)'(alpha6) - (WT_W + 2)'(beta6);
    if (gsum > (WT_W + 2)'(WT_MAX)) begin
      gamma6 = WT_MAX;
    end else if (gsum < (WT_W + 2)'(WT_MIN)) begin
      gamma6 = WT_MIN;
    end else begin
      gamma6 = WT_W'(gsum);
    end
    for (int j = 0; j < 9; j++) begin
      full8[j] = (FULL_W'(p8[j]) <<< LO_W) + FULL_W'(q8[j]);
    end
    s11x    = s11;
    s11x.rz = (sr11 == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
      v12 <= 1'b0;
    end else if (adv) begin
      v6  <= ve;
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
      v11 <= v10;
      v12 <= v11;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6     <= se;
      alpha6 <= sat_div(qa, se.neg_a);
      beta6  <= sat_div(qb, se.neg_b);
      for (int i = 0; i < 3; i++) begin
        term6[i]     <= tu[i];
        term6[3 + i] <= tv[i];
        term6[6 + i] <= tr[i];
      end

      s7     <= s6;
      wt7[0] <= alpha6;
      wt7[1] <= beta6;
      wt7[2] <= gamma6;
      term7  <= term6;

      // split each term so every product stays within 32 x 26 bits
      s8 <= s7;
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          p8[3*k + i] <= wt7[i] * $signed({1'b0, term7[3*k + i][TERM_W-1:LO_W]});
          q8[3*k + i] <= wt7[i] * $signed({1'b0, term7[3*k + i][LO_W-1:0]});
        end
      end

      s9 <= s8;
      for (int j = 0; j < 9; j++) begin
        m9[j] <= M_W'(full8[j] >>> 30);
      end

      s10  <= s9;
      su10 <= SUM_W'(m9[0]) + SUM_W'(m9[1]) + SUM_W'(m9[2]);
      sv10 <= SUM_W'(m9[3]) + SUM_W'(m9[4]) + SUM_W'(m9[5]);
      sr10 <= SUM_W'(m9[6]) + SUM_W'(m9[7]) + SUM_W'(m9[8]);

      s11  <= s10;
      pu11 <= SPROD_W'(su10) * $signed({1'b0, SCL_W});
      pv11 <= SPROD_W'(sv10) * $signed({1'b0, SCL_H});
      sr11 <= sr10;

      // truncating division: divide magnitudes, sign drops out under abs
      s12  <= s11x;
      nu12 <= pu11[SPROD_W-1] ? DIV2_NW'(-pu11) : DIV2_NW'(pu11);
      nv12 <= pv11[SPROD_W-1] ? DIV2_NW'(-pv11) : DIV2_NW'(pv11);
      dr12 <= sr11[SUM_W-1] ? DIV2_DW'(-sr11) : DIV2_DW'(sr11);
    end
  end

  logic [TXW-1:0] qmu;
  logic [TYW-1:0] qmv;
  logic           vw;
  side_t          sw;

  ptl_div #(.NUM_W(DIV2_NW), .DEN_W(DIV2_DW), .MOD(TEX_WIDTH)) u_div_u (
    .clk(clk), .en(adv), .num(nu12), .den(dr12), .quot(), .qmod(qmu)
  );
  ptl_div #(.NUM_W(DIV2_NW), .DEN_W(DIV2_DW), .MOD(TEX_HEIGHT)) u_div_v (
    .clk(clk), .en(adv), .num(nv12), .den(dr12), .quot(), .qmod(qmv)
  );
  ptl_delay #(.W($bits(side_t)), .DEPTH(DIV2_NW)) u_dly_2 (
    .clk(clk), .rst(rst), .en(adv), .v_in(v12), .d_in(s12), .v_out(vw), .d_out(sw)
  );

  // ---------------- texel address and texture store
  logic [TXW-1:0]      tx;
  logic [TYW-1:0]      ty;
  logic [ROW_W-1:0]    row_off;
  logic [STORE_AW-1:0] addr_w;

  always_comb begin
    tx      = sw.rz ? '0 : qmu;
    ty      = sw.rz ? '0 : qmv;
    row_off = SCL_W * ty;
    addr_w  = (sw.kind == REQ_TEXEL) ? sw.taddr
                                     : STORE_AW'(row_off + ROW_W'(tx));
  end

  logic                v13;
  side_t               s13;
  logic [STORE_AW-1:0] addr13;
  logic [COLOR_W-1:0]  tex_mem [TEX_DEPTH];
  logic [COLOR_W-1:0]  texq;
  side_t               s14;

  always_ff @(posedge clk) begin
    if (rst) begin
      v13       <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v13       <= vw;
      res_valid <= v13 && s13.kind == REQ_PIXEL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s13    <= sw;
      addr13 <= addr_w;
      s14    <= s13;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (v13 && s13.kind == REQ_TEXEL) begin
        tex_mem[addr13] <= s13.tcolor;
      end
      texq <= tex_mem[addr13];
    end
  end

  always_comb begin
    res.pix_x      = s14.x;
    res.pix_y      = s14.y;
    res.color      = s14.deg ? '0 : texq;
    res.degenerate = s14.deg;
  end

endmodule
`default_nettype wire

@@ rtl/ptl_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with quotient mod MOD.
`default_nettype none
module ptl_div #(
  parameter int NUM_W = 56,
  parameter int DEN_W = 32,
  parameter int MOD   = 2
) (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic [NUM_W-1:0]                           num,
  input  logic [DEN_W-1:0]                           den,
  output logic [NUM_W-1:0]                           quot,
  output logic [((MOD > 1) ? $clog2(MOD) : 1)-1:0]   qmod
);

  localparam int MW = (MOD > 1) ? $clog2(MOD) : 1;
  localparam logic [MW:0] MODV = (MW + 1)'(MOD);

  logic [NUM_W-1:0] n_o [NUM_W];
  logic [DEN_W-1:0] d_o [NUM_W];
  logic [DEN_W-1:0] r_o [NUM_W];
  logic [NUM_W-1:0] q_o [NUM_W];
  logic [MW-1:0]    m_o [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] n_i, n_q;
    logic [DEN_W-1:0] d_i, d_q, r_i, r_q;
    logic [NUM_W-1:0] q_i, q_q;
    logic [MW-1:0]    m_i, m_q;
    logic [DEN_W:0]   t;
    logic             fit;
    logic [MW:0]      mt;

    if (k == 0) begin : g_first
      assign n_i = num;
      assign d_i = den;
      assign r_i = '0;
      assign q_i = '0;
      assign m_i = '0;
    end else begin : g_next
      assign n_i = n_o[k-1];
      assign d_i = d_o[k-1];
      assign r_i = r_o[k-1];
      assign q_i = q_o[k-1];
      assign m_i = m_o[k-1];
    end

    assign t   = {r_i, n_i[NUM_W-1]};
    assign fit = (t >= {1'b0, d_i});
    // running quotient mod MOD, fed MSB first
    assign mt  = {m_i, fit};

    always_ff @(posedge clk) begin
      if (en) begin
        n_q <= n_i << 1;
        d_q <= d_i;
        r_q <= fit ? DEN_W'(t - {1'b0, d_i}) : t[DEN_W-1:0];
        q_q <= {q_i[NUM_W-2:0], fit};
        m_q <= (mt >= MODV) ? MW'(mt - MODV) : mt[MW-1:0];
      end
    end

    assign n_o[k] = n_q;
    assign d_o[k] = d_q;
    assign r_o[k] = r_q;
    assign q_o[k] = q_q;
    assign m_o[k] = m_q;
  end

  assign quot = q_o[NUM_W-1];
  assign qmod = m_o[NUM_W-1];

endmodule
`default_nettype wire

@@ rtl/ptl_delay.sv @@
// Valid and sideband shift line that runs beside a divider.
`default_nettype none
module ptl_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         v_in,
  input  logic [W-1:0] d_in,
  output logic         v_out,
  output logic [W-1:0] d_out
);

  logic [DEPTH-1:0] v_q;
  logic [W-1:0]     d_q [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[DEPTH-2:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_q[0] <= d_in;
      for (int i = 1; i < DEPTH; i++) begin
        d_q[i] <= d_q[i-1];
      end
    end
  end

  assign v_out = v_q[DEPTH-1];
  assign d_out = d_q[DEPTH-1];

endmodule
`default_nettype wire
